/* rtl/core/fapkt_pkg.sv */
package fapkt_pkg;

   localparam int MAX_SAMPLES = 4096;

   localparam int SUM_W   = 20;
   localparam int COUNT_W = 13;
   localparam int STEP_W  = 12;
   localparam int CHAN_W  = 8;
   localparam int BRIGHT_W = 9;
   localparam int LED_W   = 8;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   // the count stops at MAX_SAMPLES or at the largest value its register holds
   localparam int COUNT_LIMIT_INT = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_LIMIT_INT);

   localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'hff;
   localparam logic [7:0]        PACKET_TYPE = 8'h30;
   localparam logic [7:0]        PACKET_STOP = 8'h03;

   localparam logic [STEP_W-1:0]   STEP_X_RESET     = 12'd96;
   localparam logic [STEP_W-1:0]   STEP_Y_RESET     = 12'd54;
   localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RESET = 9'd256;
   localparam logic [LED_W-1:0]    FIRST_LED_RESET  = 8'd0;
   localparam logic [LED_W-1:0]    FINAL_LED_RESET  = 8'd81;

   // finished frame handed from the sampler to the divider
   typedef struct packed {
      logic [SUM_W-1:0]   sum_red;
      logic [SUM_W-1:0]   sum_green;
      logic [SUM_W-1:0]   sum_blue;
      logic [COUNT_W-1:0] count;
   } fapkt_frame_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fapkt_queue_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fapkt_queue_sts_type;

endpackage

/* rtl/core/fapkt_front.sv */
module fapkt_front import fapkt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [STEP_W-1:0]     step_x,
   input  logic [STEP_W-1:0]     step_y,
   input  logic                  pixel_accept,
   input  logic [23:0]           pixel_rgb,
   input  logic                  end_of_line,
   input  logic                  end_of_frame,
   output logic                  frame_push,
   output fapkt_frame_type       frame_job
);

   logic [SUM_W-1:0]   sum_red_ff, sum_green_ff, sum_blue_ff;
   logic [SUM_W-1:0]   sum_red_in, sum_green_in, sum_blue_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [STEP_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic               take_sample;
   logic [SUM_W-1:0]   add_red, add_green, add_blue;
   logic [SUM_W-1:0]   acc_red, acc_green, acc_blue;
   logic [COUNT_W-1:0] acc_count;
   logic [STEP_W-1:0]  col_adv, row_adv;

   function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] sum,
                                                input logic [CHAN_W-1:0] chan);
      logic [SUM_W:0] t;
      t = {1'b0, sum} + {{(SUM_W+1-CHAN_W){1'b0}}, chan};
      return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
   endfunction

   // step of zero behaves as one; a phase beyond a smaller new step wraps
   function automatic logic [STEP_W-1:0] advance(input logic [STEP_W-1:0] phase,
                                                 input logic [STEP_W-1:0] step);
      logic [STEP_W-1:0] s;
      logic [STEP_W:0]   n;
      s = (step == '0) ? STEP_W'(1) : step;
      n = {1'b0, phase} + (STEP_W+1)'(1);
      return (n >= {1'b0, s}) ? '0 : n[STEP_W-1:0];
   endfunction

   always_comb begin
      take_sample = (col_ff == '0) && (row_ff == '0) && (count_ff < COUNT_LIMIT);
      add_red   = add_sat(sum_red_ff,   pixel_rgb[23:16]);
      add_green = add_sat(sum_green_ff, pixel_rgb[15:8]);
      add_blue  = add_sat(sum_blue_ff,  pixel_rgb[7:0]);
      acc_red   = take_sample ? add_red   : sum_red_ff;
      acc_green = take_sample ? add_green : sum_green_ff;
      acc_blue  = take_sample ? add_blue  : sum_blue_ff;
      acc_count = take_sample ? count_ff + COUNT_W'(1) : count_ff;
      col_adv   = advance(col_ff, step_x);
      row_adv   = advance(row_ff, step_y);

      sum_red_in   = sum_red_ff;
      sum_green_in = sum_green_ff;
      sum_blue_in  = sum_blue_ff;
      count_in     = count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (pixel_accept) begin
         if (end_of_frame) begin
            sum_red_in   = '0;
            sum_green_in = '0;
            sum_blue_in  = '0;
            count_in     = '0;
            col_in       = '0;
            row_in       = '0;
         end else begin
            sum_red_in   = acc_red;
            sum_green_in = acc_green;
            sum_blue_in  = acc_blue;
            count_in     = acc_count;
            if (end_of_line) begin
               col_in = '0;
               row_in = row_adv;
            end else begin
               col_in = col_adv;
            end
         end
      end

      frame_push          = pixel_accept && end_of_frame && (acc_count != '0);
      frame_job.sum_red   = acc_red;
      frame_job.sum_green = acc_green;
      frame_job.sum_blue  = acc_blue;
      frame_job.count     = acc_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_red_ff   <= '0;
         sum_green_ff <= '0;
         sum_blue_ff  <= '0;
         count_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         sum_red_ff   <= sum_red_in;
         sum_green_ff <= sum_green_in;
         sum_blue_ff  <= sum_blue_in;
         count_ff     <= count_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

endmodule

/* rtl/core/fapkt_queue.sv */
module fapkt_queue import fapkt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  fapkt_queue_ctl_type  ctl,
   input  fapkt_frame_type      wr_job,
   output fapkt_frame_type      rd_job,
   output fapkt_queue_sts_type  sts
);

   fapkt_frame_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]      fill_ff, fill_in;
   logic            do_push, do_pop;

   always_comb begin
      sts.full  = (fill_ff == 2'd2);
      sts.empty = (fill_ff == 2'd0);
      do_push   = ctl.push && !sts.full;
      do_pop    = ctl.pop && !sts.empty;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
      rd_job    = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* rtl/core/fapkt_back.sv */
module fapkt_back import fapkt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BRIGHT_W-1:0]  brightness_q8,
   input  logic [LED_W-1:0]     first_led,
   input  logic [LED_W-1:0]     final_led,
   input  fapkt_frame_type      job,
   input  logic                 job_ready,
   output logic                 job_take,
   output logic                 byte_valid,
   input  logic                 byte_ready,
   output logic [7:0]           byte_data,
   output logic                 byte_last
);

   typedef enum logic [1:0] {IDLE, DIVIDE, SCALE, SEND} state_type;
   typedef enum logic [2:0] {
      BYTE_TYPE, BYTE_FIRST, BYTE_FINAL, BYTE_RED, BYTE_GREEN, BYTE_BLUE, BYTE_STOP
   } byte_sel_type;

   localparam logic [4:0] LAST_STEP = 5'(SUM_W - 1);

   state_type          state_ff, state_in;
   byte_sel_type       sel_ff, sel_in;
   logic [4:0]         step_ff, step_in;
   logic [COUNT_W-1:0] divisor_ff, divisor_in;
   // one restoring-division lane per channel: red, green, blue
   logic [COUNT_W-1:0] rem_ff [3];
   logic [COUNT_W-1:0] rem_in [3];
   logic [SUM_W-1:0]   quo_ff [3];
   logic [SUM_W-1:0]   quo_in [3];
   logic [CHAN_W-1:0]  last_ff [3];
   logic [CHAN_W-1:0]  last_in [3];
   logic [CHAN_W-1:0]  scaled [3];
   logic               valid_ff, valid_in, last_byte_ff, last_byte_in;
   logic [7:0]         data_ff, data_in;
   logic [COUNT_W:0]   trial;
   logic [CHAN_W-1:0]  avg;
   logic [CHAN_W+BRIGHT_W-1:0] prod;
   logic               out_free, same_color;
   logic [7:0]         next_byte;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         trial  = {rem_ff[l], quo_ff[l][SUM_W-1]};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in[l] = COUNT_W'(trial - {1'b0, divisor_ff});
            quo_in[l] = {quo_ff[l][SUM_W-2:0], 1'b1};
         end else begin
            rem_in[l] = trial[COUNT_W-1:0];
            quo_in[l] = {quo_ff[l][SUM_W-2:0], 1'b0};
         end
         avg       = (quo_ff[l][SUM_W-1:CHAN_W] != '0) ? CHAN_MAX : quo_ff[l][CHAN_W-1:0];
         prod      = {{BRIGHT_W{1'b0}}, avg} * {{CHAN_W{1'b0}}, brightness_q8};
         scaled[l] = prod[CHAN_W+BRIGHT_W-1] ? CHAN_MAX : prod[CHAN_W+BRIGHT_W-2:CHAN_W];
      end
      same_color = (scaled[0] == last_ff[0]) && (scaled[1] == last_ff[1]) &&
                   (scaled[2] == last_ff[2]);

      case (sel_ff)
         BYTE_TYPE:  next_byte = PACKET_TYPE;
         BYTE_FIRST: next_byte = first_led;
         BYTE_FINAL: next_byte = final_led;
         BYTE_RED:   next_byte = last_ff[0];
         BYTE_GREEN: next_byte = last_ff[1];
         BYTE_BLUE:  next_byte = last_ff[2];
         default:    next_byte = PACKET_STOP;
      endcase

      out_free     = !valid_ff || byte_ready;
      state_in     = state_ff;
      sel_in       = sel_ff;
      step_in      = step_ff;
      divisor_in   = divisor_ff;
      last_in      = last_ff;
      valid_in     = byte_ready ? 1'b0 : valid_ff;
      data_in      = data_ff;
      last_byte_in = last_byte_ff;
      job_take     = 1'b0;

      case (state_ff)
         IDLE: begin
            if (job_ready) begin
               job_take   = 1'b1;
               divisor_in = job.count;
               step_in    = '0;
               state_in   = DIVIDE;
            end
         end
         DIVIDE: begin
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               state_in = SCALE;
            end
         end
         SCALE: begin
            if (same_color) begin
               state_in = IDLE;
            end else begin
               last_in  = scaled;
               sel_in   = BYTE_TYPE;
               state_in = SEND;
            end
         end
         SEND: begin
            if (out_free) begin
               valid_in     = 1'b1;
               data_in      = next_byte;
               last_byte_in = (sel_ff == BYTE_STOP);
               if (sel_ff == BYTE_STOP) begin
                  state_in = IDLE;
               end else begin
                  sel_in = byte_sel_type'(sel_ff + 3'd1);
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         rem_ff[0] <= '0;
         rem_ff[1] <= '0;
         rem_ff[2] <= '0;
         quo_ff[0] <= job.sum_red;
         quo_ff[1] <= job.sum_green;
         quo_ff[2] <= job.sum_blue;
      end else if (state_ff == DIVIDE) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         sel_ff       <= BYTE_TYPE;
         valid_ff     <= 1'b0;
         data_ff      <= '0;
         last_byte_ff <= 1'b0;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
         last_ff[2]   <= '0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         valid_ff     <= valid_in;
         data_ff      <= data_in;
         last_byte_ff <= last_byte_in;
         last_ff      <= last_in;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;
   assign byte_last  = last_byte_ff;

endmodule

/* rtl/core/frame_average_color_packet.sv */
// Averages sampled pixels of each frame and sends a 7-byte LED packet
// (0x30, first LED, last LED, R, G, B, 0x03) whenever the averaged,
// brightness-scaled color differs from the last one sent. Pixels are taken
// one per clock while the two-entry frame queue has room; any pixel, also
// one inside a frame, is held off while that queue is full. The frame-end pixel
// pushes the sums. Each queued frame is loaded, divided bit-serially (three
// channel lanes share one step counter), then scaled and compared; if the
// color changed, 7 byte transactions follow on the result port, one per
// cycle when rsp_tready stays high. Configuration writes are taken at any
// time with csr_ready tied high; indexes 5 to 7 are ignored.
module frame_average_color_packet import fapkt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_rgb[23:0]
   input  logic        req_tuser,   // end_of_line
   input  logic        req_tlast,   // end_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // packet_byte[7:0]
   output logic        rsp_tlast,   // packet_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam logic [2:0] CSR_STEP_X     = 3'd0;
   localparam logic [2:0] CSR_STEP_Y     = 3'd1;
   localparam logic [2:0] CSR_BRIGHTNESS = 3'd2;
   localparam logic [2:0] CSR_FIRST_LED  = 3'd3;
   localparam logic [2:0] CSR_FINAL_LED  = 3'd4;

   logic [STEP_W-1:0]   step_x_ff, step_y_ff;
   logic [BRIGHT_W-1:0] brightness_ff;
   logic [LED_W-1:0]    first_led_ff, final_led_ff;
   logic                pixel_accept, csr_write;
   logic                frame_push, job_take;
   fapkt_frame_type     push_job, head_job;
   fapkt_queue_ctl_type q_ctl;
   fapkt_queue_sts_type q_sts;

   assign csr_ready    = 1'b1;
   assign csr_write    = csr_valid && csr_ready;
   assign req_tready   = !q_sts.full;
   assign pixel_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff     <= STEP_X_RESET;
         step_y_ff     <= STEP_Y_RESET;
         brightness_ff <= BRIGHTNESS_RESET;
         first_led_ff  <= FIRST_LED_RESET;
         final_led_ff  <= FINAL_LED_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEP_X:     step_x_ff     <= csr_data;
            CSR_STEP_Y:     step_y_ff     <= csr_data;
            CSR_BRIGHTNESS: brightness_ff <= csr_data[BRIGHT_W-1:0];
            CSR_FIRST_LED:  first_led_ff  <= csr_data[LED_W-1:0];
            CSR_FINAL_LED:  final_led_ff  <= csr_data[LED_W-1:0];
            default: ;
         endcase
      end
   end

   fapkt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .step_x       (step_x_ff),
      .step_y       (step_y_ff),
      .pixel_accept (pixel_accept),
      .pixel_rgb    (req_tdata),
      .end_of_line  (req_tuser),
      .end_of_frame (req_tlast),
      .frame_push   (frame_push),
      .frame_job    (push_job)
   );

   assign q_ctl.push = frame_push;
   assign q_ctl.pop  = job_take;

   fapkt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctl    (q_ctl),
      .wr_job (push_job),
      .rd_job (head_job),
      .sts    (q_sts)
   );

   fapkt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .brightness_q8 (brightness_ff),
      .first_led     (first_led_ff),
      .final_led     (final_led_ff),
      .job           (head_job),
      .job_ready     (!q_sts.empty),
      .job_take      (job_take),
      .byte_valid    (rsp_tvalid),
      .byte_ready    (rsp_tready),
      .byte_data     (rsp_tdata),
      .byte_last     (rsp_tlast)
   );

endmodule
